@@ rtl/core/psc_pkg.sv @@
// shared types and constants of the particle segment collision unit
package psc_pkg;

  // one particle and segment pair
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic        [30:0] particle_radius;
    logic        [15:0] bounce_coef;
    logic        [15:0] friction_coef;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic        [30:0] seg_thickness;
  } in_t;

  // corrected particle
  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_prev_x;
    logic signed [31:0] new_prev_y;
    logic               hit;
    logic               bounced;
  } out_t;

  // side data carried through the square root and normal divider pipes
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic        [15:0] ke;
    logic        [15:0] kf;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic        [32:0] reach;
    logic               hit;
  } ctx_t;

  localparam logic [15:0] CoefOne    = 16'd32768;
  localparam int unsigned TdivSteps  = 30;
  localparam int unsigned SqrtSteps  = 32;
  localparam int unsigned NdivSteps  = 31;

endpackage

@@ rtl/core/psc_isqrt.sv @@
// pipelined integer square root, one result bit per stage
module psc_isqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [63:0]       ds_i,
  input  psc_pkg::ctx_t     ctx_i,
  output logic              valid_o,
  output logic [31:0]       dist_o,
  output psc_pkg::ctx_t     ctx_o
);

  localparam int unsigned Steps = psc_pkg::SqrtSteps;

  logic          vld_q [Steps];
  logic [63:0]   rem_q [Steps];
  logic [63:0]   root_q [Steps];
  psc_pkg::ctx_t ctx_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic          vin;
    logic [63:0]   rin;
    logic [63:0]   oin;
    psc_pkg::ctx_t cin;
    logic [64:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign rin = ds_i;
      assign oin = '0;
      assign cin = ctx_i;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign rin = rem_q[k-1];
      assign oin = root_q[k-1];
      assign cin = ctx_q[k-1];
    end

    assign trial = {1'b0, oin} + {1'b0, Bit};
    assign ge    = {1'b0, rin} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ge) begin
        rem_q[k]  <= rin - trial[63:0];
        root_q[k] <= (oin >> 1) + Bit;
      end else begin
        rem_q[k]  <= rin;
        root_q[k] <= oin >> 1;
      end
      ctx_q[k] <= cin;
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign dist_o  = root_q[Steps-1][31:0];
  assign ctx_o   = ctx_q[Steps-1];

endmodule

@@ rtl/core/psc_ndiv.sv @@
// pipelined unit normal divider, d * 2^30 / dist for both axes
module psc_ndiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [31:0]        dist_i,
  input  psc_pkg::ctx_t      ctx_i,
  output logic               valid_o,
  output logic [31:0]        dist_o,
  output logic signed [31:0] nx_o,
  output logic signed [31:0] ny_o,
  output psc_pkg::ctx_t      ctx_o
);

  localparam int unsigned Steps = psc_pkg::NdivSteps;

  logic          vld_q  [Steps];
  logic [31:0]   dist_q [Steps];
  logic [33:0]   rx_q   [Steps];
  logic [33:0]   ry_q   [Steps];
  logic [30:0]   qx_q   [Steps];
  logic [30:0]   qy_q   [Steps];
  psc_pkg::ctx_t ctx_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic          vin;
    logic [31:0]   din;
    logic [33:0]   rxin;
    logic [33:0]   ryin;
    logic [30:0]   qxin;
    logic [30:0]   qyin;
    psc_pkg::ctx_t cin;
    logic [34:0]   cx;
    logic [34:0]   cy;
    logic          gex;
    logic          gey;

    if (k == 0) begin : g_first
      assign vin  = valid_i;
      assign din  = dist_i;
      assign rxin = ctx_i.dx[33] ? 34'(-ctx_i.dx) : 34'(ctx_i.dx);
      assign ryin = ctx_i.dy[33] ? 34'(-ctx_i.dy) : 34'(ctx_i.dy);
      assign qxin = '0;
      assign qyin = '0;
      assign cin  = ctx_i;
      assign cx   = {1'b0, rxin};
      assign cy   = {1'b0, ryin};
    end else begin : g_next
      assign vin  = vld_q[k-1];
      assign din  = dist_q[k-1];
      assign rxin = rx_q[k-1];
      assign ryin = ry_q[k-1];
      assign qxin = qx_q[k-1];
      assign qyin = qy_q[k-1];
      assign cin  = ctx_q[k-1];
      assign cx   = {rxin, 1'b0};
      assign cy   = {ryin, 1'b0};
    end

    assign gex = cx >= {3'b000, din};
    assign gey = cy >= {3'b000, din};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rx_q[k]   <= gex ? 34'(cx - {3'b000, din}) : cx[33:0];
      ry_q[k]   <= gey ? 34'(cy - {3'b000, din}) : cy[33:0];
      qx_q[k]   <= {qxin[29:0], gex};
      qy_q[k]   <= {qyin[29:0], gey};
      dist_q[k] <= din;
      ctx_q[k]  <= cin;
    end
  end

  // sign stage, zero distance gives a zero normal
  logic               out_vld_q;
  logic [31:0]        out_dist_q;
  logic signed [31:0] out_nx_q;
  logic signed [31:0] out_ny_q;
  psc_pkg::ctx_t      out_ctx_q;
  logic signed [31:0] qxs;
  logic signed [31:0] qys;

  assign qxs = $signed({1'b0, qx_q[Steps-1]});
  assign qys = $signed({1'b0, qy_q[Steps-1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_q[Steps-1] == '0) begin
      out_nx_q <= '0;
      out_ny_q <= '0;
    end else begin
      out_nx_q <= ctx_q[Steps-1].dx[33] ? -qxs : qxs;
      out_ny_q <= ctx_q[Steps-1].dy[33] ? -qys : qys;
    end
    out_dist_q <= dist_q[Steps-1];
    out_ctx_q  <= ctx_q[Steps-1];
  end

  assign valid_o = out_vld_q;
  assign dist_o  = out_dist_q;
  assign nx_o    = out_nx_q;
  assign ny_o    = out_ny_q;
  assign ctx_o   = out_ctx_q;

endmodule

@@ rtl/core/particle_segment_collision_unit.sv @@
// top level: verlet particle against thick segment, push-out and bounce response
// throughput: one pair per cycle; the 30-step projection divider, 32-step square root
//   and 31-step normal divider are fully unrolled into stages, so busy never rises
// reset: rst_ni clears every stage valid bit and the strobe; data registers keep no reset
// results cannot be held off: each one is shown for exactly one cycle
module particle_segment_collision_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  psc_pkg::in_t   item_i,
  output logic           done_o,
  output psc_pkg::out_t  result_o
);

  localparam int unsigned TSteps = psc_pkg::TdivSteps;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic        [30:0] rad;
    logic        [30:0] thick;
    logic        [15:0] ke;
    logic        [15:0] kf;
    logic signed [32:0] tx;
    logic signed [32:0] ty;
  } fctx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic        [15:0] ke;
    logic        [15:0] kf;
    logic               hit;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic signed [34:0] npx;
    logic signed [34:0] npy;
    logic signed [34:0] nqx;
    logic signed [34:0] nqy;
    logic               bounce;
  } post_t;

  localparam logic signed [40:0] SatHi = 41'sd2147483647;
  localparam logic signed [40:0] SatLo = -41'sd2147483648;

  // magnitude rounding shift, halves away from zero
  function automatic logic signed [69:0] rnd_shr(input logic signed [69:0] v,
                                                 input int unsigned s);
    logic [69:0] mag;
    logic [69:0] r;
    mag = v[69] ? 70'(-v) : 70'(v);
    r   = (mag + (70'd1 << (s - 1))) >> s;
    return v[69] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > SatHi) begin
      r = SatHi[31:0];
    end else if (v < SatLo) begin
      r = SatLo[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // the pipeline never stalls
  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------------------
  // s0: segment vector, particle offset, coefficient clamp
  // ---------------------------------------------------------------------------
  logic               s0_vld_q;
  fctx_t              s0_ctx_q;
  logic signed [32:0] s0_dx_q;
  logic signed [32:0] s0_dy_q;
  logic [15:0]        e_sat;
  logic [15:0]        f_sat;

  assign e_sat = (item_i.bounce_coef > psc_pkg::CoefOne) ? psc_pkg::CoefOne
                                                         : item_i.bounce_coef;
  assign f_sat = (item_i.friction_coef > psc_pkg::CoefOne) ? psc_pkg::CoefOne
                                                           : item_i.friction_coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_ctx_q.pos_x  <= item_i.pos_x;
    s0_ctx_q.pos_y  <= item_i.pos_y;
    s0_ctx_q.prev_x <= item_i.prev_x;
    s0_ctx_q.prev_y <= item_i.prev_y;
    s0_ctx_q.sx     <= item_i.seg_start_x;
    s0_ctx_q.sy     <= item_i.seg_start_y;
    s0_ctx_q.rad    <= item_i.particle_radius;
    s0_ctx_q.thick  <= item_i.seg_thickness;
    s0_ctx_q.ke     <= e_sat;
    s0_ctx_q.kf     <= psc_pkg::CoefOne - f_sat;
    s0_ctx_q.tx     <= 33'(item_i.seg_end_x) - 33'(item_i.seg_start_x);
    s0_ctx_q.ty     <= 33'(item_i.seg_end_y) - 33'(item_i.seg_start_y);
    s0_dx_q         <= 33'(item_i.pos_x) - 33'(item_i.seg_start_x);
    s0_dy_q         <= 33'(item_i.pos_y) - 33'(item_i.seg_start_y);
  end

  // ---------------------------------------------------------------------------
  // s1: dot product terms and squared segment length terms
  // ---------------------------------------------------------------------------
  logic               s1_vld_q;
  fctx_t              s1_ctx_q;
  logic signed [65:0] s1_pdx_q;
  logic signed [65:0] s1_pdy_q;
  logic signed [65:0] s1_ptx_q;
  logic signed [65:0] s1_pty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ctx_q <= s0_ctx_q;
    s1_pdx_q <= s0_dx_q * s0_ctx_q.tx;
    s1_pdy_q <= s0_dy_q * s0_ctx_q.ty;
    s1_ptx_q <= s0_ctx_q.tx * s0_ctx_q.tx;
    s1_pty_q <= s0_ctx_q.ty * s0_ctx_q.ty;
  end

  // ---------------------------------------------------------------------------
  // s2: clamp decisions for the projection parameter
  // ---------------------------------------------------------------------------
  logic               s2_vld_q;
  fctx_t              s2_ctx_q;
  logic               s2_zero_q;
  logic               s2_one_q;
  logic [64:0]        s2_num_q;
  logic [64:0]        s2_den_q;
  logic signed [66:0] dot;
  logic [64:0]        den;

  assign dot = 67'(s1_pdx_q) + 67'(s1_pdy_q);
  assign den = {1'b0, s1_ptx_q[63:0]} + {1'b0, s1_pty_q[63:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ctx_q  <= s1_ctx_q;
    s2_zero_q <= dot <= 67'sd0;
    s2_one_q  <= dot >= $signed({2'b00, den});
    s2_num_q  <= dot[64:0];
    s2_den_q  <= den;
  end

  // ---------------------------------------------------------------------------
  // projection divider: one quotient bit per stage, msb first
  // ---------------------------------------------------------------------------
  logic        td_vld_q  [TSteps];
  fctx_t       td_ctx_q  [TSteps];
  logic [64:0] td_rem_q  [TSteps];
  logic [64:0] td_den_q  [TSteps];
  logic [29:0] td_quo_q  [TSteps];
  logic        td_zero_q [TSteps];
  logic        td_one_q  [TSteps];

  for (genvar k = 0; k < TSteps; k++) begin : g_tdiv
    logic        vin;
    fctx_t       cin;
    logic [64:0] rin;
    logic [64:0] din;
    logic [29:0] qin;
    logic        zin;
    logic        oin;
    logic [65:0] cand;
    logic        ge;

    if (k == 0) begin : g_first
      assign vin = s2_vld_q;
      assign cin = s2_ctx_q;
      assign rin = s2_num_q;
      assign din = s2_den_q;
      assign qin = '0;
      assign zin = s2_zero_q;
      assign oin = s2_one_q;
    end else begin : g_next
      assign vin = td_vld_q[k-1];
      assign cin = td_ctx_q[k-1];
      assign rin = td_rem_q[k-1];
      assign din = td_den_q[k-1];
      assign qin = td_quo_q[k-1];
      assign zin = td_zero_q[k-1];
      assign oin = td_one_q[k-1];
    end

    assign cand = {rin, 1'b0};
    assign ge   = cand >= {1'b0, din};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        td_vld_q[k] <= 1'b0;
      end else begin
        td_vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      td_rem_q[k]  <= ge ? 65'(cand - {1'b0, din}) : cand[64:0];
      td_quo_q[k]  <= {qin[28:0], ge};
      td_den_q[k]  <= din;
      td_ctx_q[k]  <= cin;
      td_zero_q[k] <= zin;
      td_one_q[k]  <= oin;
    end
  end

  // clamped parameter t in q1.30
  logic [30:0] t_val;
  always_comb begin
    if (td_zero_q[TSteps-1]) begin
      t_val = '0;
    end else if (td_one_q[TSteps-1]) begin
      t_val = 31'd1 << 30;
    end else begin
      t_val = {1'b0, td_quo_q[TSteps-1]};
    end
  end

  // ---------------------------------------------------------------------------
  // s3: segment vector scaled by t
  // ---------------------------------------------------------------------------
  logic               s3_vld_q;
  fctx_t              s3_ctx_q;
  logic signed [64:0] s3_pcx_q;
  logic signed [64:0] s3_pcy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= td_vld_q[TSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    s3_ctx_q <= td_ctx_q[TSteps-1];
    s3_pcx_q <= td_ctx_q[TSteps-1].tx * $signed({1'b0, t_val});
    s3_pcy_q <= td_ctx_q[TSteps-1].ty * $signed({1'b0, t_val});
  end

  // ---------------------------------------------------------------------------
  // s4: closest point on the segment
  // ---------------------------------------------------------------------------
  logic               s4_vld_q;
  fctx_t              s4_ctx_q;
  logic signed [33:0] s4_clx_q;
  logic signed [33:0] s4_cly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_ctx_q <= s3_ctx_q;
    s4_clx_q <= 34'(s3_ctx_q.sx) + 34'(rnd_shr(70'(s3_pcx_q), 30));
    s4_cly_q <= 34'(s3_ctx_q.sy) + 34'(rnd_shr(70'(s3_pcy_q), 30));
  end

  // ---------------------------------------------------------------------------
  // s5: offset from the closest point and its magnitudes
  // ---------------------------------------------------------------------------
  logic               s5_vld_q;
  fctx_t              s5_ctx_q;
  logic signed [34:0] s5_dx_q;
  logic signed [34:0] s5_dy_q;
  logic [33:0]        s5_ax_q;
  logic [33:0]        s5_ay_q;
  logic [31:0]        s5_h_q;
  logic               s5_odd_q;
  logic signed [34:0] dx5;
  logic signed [34:0] dy5;

  assign dx5 = 35'(s4_ctx_q.pos_x) - 35'(s4_clx_q);
  assign dy5 = 35'(s4_ctx_q.pos_y) - 35'(s4_cly_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_ctx_q <= s4_ctx_q;
    s5_dx_q  <= dx5;
    s5_dy_q  <= dy5;
    s5_ax_q  <= dx5[34] ? 34'(-dx5) : 34'(dx5);
    s5_ay_q  <= dy5[34] ? 34'(-dy5) : 34'(dy5);
    // half thickness plus radius, the odd bit keeps the full thickness exact
    s5_h_q   <= {1'b0, s4_ctx_q.rad} + {2'b00, s4_ctx_q.thick[30:1]};
    s5_odd_q <= s4_ctx_q.thick[0];
  end

  // ---------------------------------------------------------------------------
  // s6: squares
  // ---------------------------------------------------------------------------
  logic               s6_vld_q;
  fctx_t              s6_ctx_q;
  logic signed [34:0] s6_dx_q;
  logic signed [34:0] s6_dy_q;
  logic [63:0]        s6_axsq_q;
  logic [63:0]        s6_aysq_q;
  logic [63:0]        s6_hsq_q;
  logic [31:0]        s6_h_q;
  logic               s6_odd_q;
  logic               s6_far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_ctx_q  <= s5_ctx_q;
    s6_dx_q   <= s5_dx_q;
    s6_dy_q   <= s5_dy_q;
    // squares only matter when both magnitudes are within reach
    s6_axsq_q <= s5_ax_q[31:0] * s5_ax_q[31:0];
    s6_aysq_q <= s5_ay_q[31:0] * s5_ay_q[31:0];
    s6_hsq_q  <= s5_h_q * s5_h_q;
    s6_h_q    <= s5_h_q;
    s6_odd_q  <= s5_odd_q;
    s6_far_q  <= (s5_ax_q > {2'b00, s5_h_q}) || (s5_ay_q > {2'b00, s5_h_q});
  end

  // ---------------------------------------------------------------------------
  // s7: overlap test, 4*ds <= (2r + thickness)^2 done as ds <= h^2 + odd*h
  // ---------------------------------------------------------------------------
  logic          s7_vld_q;
  logic [63:0]   s7_ds_q;
  psc_pkg::ctx_t s7_ctx_q;
  logic [64:0]   ds65;
  logic [64:0]   lim65;

  assign ds65  = {1'b0, s6_axsq_q} + {1'b0, s6_aysq_q};
  assign lim65 = {1'b0, s6_hsq_q} + (s6_odd_q ? {33'd0, s6_h_q} : 65'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_ds_q         <= ds65[63:0];
    s7_ctx_q.pos_x  <= s6_ctx_q.pos_x;
    s7_ctx_q.pos_y  <= s6_ctx_q.pos_y;
    s7_ctx_q.prev_x <= s6_ctx_q.prev_x;
    s7_ctx_q.prev_y <= s6_ctx_q.prev_y;
    s7_ctx_q.ke     <= s6_ctx_q.ke;
    s7_ctx_q.kf     <= s6_ctx_q.kf;
    s7_ctx_q.dx     <= s6_dx_q[33:0];
    s7_ctx_q.dy     <= s6_dy_q[33:0];
    s7_ctx_q.reach  <= {s6_h_q, s6_odd_q};
    s7_ctx_q.hit    <= !s6_far_q && (ds65 <= lim65);
  end

  // ---------------------------------------------------------------------------
  // distance and unit normal
  // ---------------------------------------------------------------------------
  logic               sq_vld;
  logic [31:0]        sq_dist;
  psc_pkg::ctx_t      sq_ctx;
  logic               nd_vld;
  logic [31:0]        nd_dist;
  logic signed [31:0] nd_nx;
  logic signed [31:0] nd_ny;
  psc_pkg::ctx_t      nd_ctx;

  psc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s7_vld_q),
    .ds_i    (s7_ds_q),
    .ctx_i   (s7_ctx_q),
    .valid_o (sq_vld),
    .dist_o  (sq_dist),
    .ctx_o   (sq_ctx)
  );

  psc_ndiv u_ndiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .dist_i  (sq_dist),
    .ctx_i   (sq_ctx),
    .valid_o (nd_vld),
    .dist_o  (nd_dist),
    .nx_o    (nd_nx),
    .ny_o    (nd_ny),
    .ctx_o   (nd_ctx)
  );

  // ---------------------------------------------------------------------------
  // p0: overlap depth and implied velocity
  // ---------------------------------------------------------------------------
  logic               p0_vld_q;
  post_t              p0_q;
  logic signed [34:0] p0_ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q <= 1'b0;
    end else begin
      p0_vld_q <= nd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q.pos_x  <= nd_ctx.pos_x;
    p0_q.pos_y  <= nd_ctx.pos_y;
    p0_q.prev_x <= nd_ctx.prev_x;
    p0_q.prev_y <= nd_ctx.prev_y;
    p0_q.ke     <= nd_ctx.ke;
    p0_q.kf     <= nd_ctx.kf;
    p0_q.hit    <= nd_ctx.hit;
    p0_q.nx     <= nd_nx;
    p0_q.ny     <= nd_ny;
    p0_q.vx     <= 33'(nd_ctx.pos_x) - 33'(nd_ctx.prev_x);
    p0_q.vy     <= 33'(nd_ctx.pos_y) - 33'(nd_ctx.prev_y);
    p0_q.npx    <= '0;
    p0_q.npy    <= '0;
    p0_q.nqx    <= '0;
    p0_q.nqy    <= '0;
    p0_q.bounce <= 1'b0;
    p0_ov_q     <= $signed({2'b00, nd_ctx.reach}) - $signed({2'b00, nd_dist, 1'b0});
  end

  // ---------------------------------------------------------------------------
  // p1: push-out and approach products
  // ---------------------------------------------------------------------------
  logic               p1_vld_q;
  post_t              p1_q;
  logic signed [66:0] p1_mox_q;
  logic signed [66:0] p1_moy_q;
  logic signed [64:0] p1_mvx_q;
  logic signed [64:0] p1_mvy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= p0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q     <= p0_q;
    p1_mox_q <= p0_ov_q * p0_q.nx;
    p1_moy_q <= p0_ov_q * p0_q.ny;
    p1_mvx_q <= p0_q.vx * p0_q.nx;
    p1_mvy_q <= p0_q.vy * p0_q.ny;
  end

  // ---------------------------------------------------------------------------
  // p2: pushed positions, approach test
  // ---------------------------------------------------------------------------
  logic               p2_vld_q;
  post_t              p2_q;
  post_t              p2_d;
  logic signed [65:0] p2_vraw_q;
  logic signed [34:0] shx;
  logic signed [34:0] shy;
  logic signed [65:0] vraw;

  assign shx  = 35'(rnd_shr(70'(p1_mox_q), 31));
  assign shy  = 35'(rnd_shr(70'(p1_moy_q), 31));
  assign vraw = 66'(p1_mvx_q) + 66'(p1_mvy_q);

  always_comb begin
    p2_d        = p1_q;
    p2_d.npx    = 35'(p1_q.pos_x) + shx;
    p2_d.npy    = 35'(p1_q.pos_y) + shy;
    p2_d.nqx    = 35'(p1_q.prev_x) + shx;
    p2_d.nqy    = 35'(p1_q.prev_y) + shy;
    p2_d.bounce = vraw[65];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_q      <= p2_d;
    p2_vraw_q <= vraw;
  end

  // ---------------------------------------------------------------------------
  // p3: normal speed
  // ---------------------------------------------------------------------------
  logic               p3_vld_q;
  post_t              p3_q;
  logic signed [34:0] p3_vn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p3_q    <= p2_q;
    p3_vn_q <= 35'(rnd_shr(70'(p2_vraw_q), 30));
  end

  // ---------------------------------------------------------------------------
  // p4: normal velocity products
  // ---------------------------------------------------------------------------
  logic               p4_vld_q;
  post_t              p4_q;
  logic signed [66:0] p4_pvx_q;
  logic signed [66:0] p4_pvy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_vld_q <= 1'b0;
    end else begin
      p4_vld_q <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p4_q     <= p3_q;
    p4_pvx_q <= p3_vn_q * p3_q.nx;
    p4_pvy_q <= p3_vn_q * p3_q.ny;
  end

  // ---------------------------------------------------------------------------
  // p5: split velocity into normal and tangential parts
  // ---------------------------------------------------------------------------
  logic               p5_vld_q;
  post_t              p5_q;
  logic signed [34:0] p5_vnx_q;
  logic signed [34:0] p5_vny_q;
  logic signed [35:0] p5_vtx_q;
  logic signed [35:0] p5_vty_q;
  logic signed [34:0] vnx;
  logic signed [34:0] vny;

  assign vnx = 35'(rnd_shr(70'(p4_pvx_q), 30));
  assign vny = 35'(rnd_shr(70'(p4_pvy_q), 30));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_vld_q <= 1'b0;
    end else begin
      p5_vld_q <= p4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p5_q     <= p4_q;
    p5_vnx_q <= vnx;
    p5_vny_q <= vny;
    p5_vtx_q <= 36'(p4_q.vx) - 36'(vnx);
    p5_vty_q <= 36'(p4_q.vy) - 36'(vny);
  end

  // ---------------------------------------------------------------------------
  // p6: restitution and friction products
  // ---------------------------------------------------------------------------
  logic               p6_vld_q;
  post_t              p6_q;
  logic signed [51:0] p6_ax_q;
  logic signed [51:0] p6_ay_q;
  logic signed [52:0] p6_bx_q;
  logic signed [52:0] p6_by_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p6_vld_q <= 1'b0;
    end else begin
      p6_vld_q <= p5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p6_q    <= p5_q;
    p6_ax_q <= $signed({1'b0, p5_q.ke}) * p5_vnx_q;
    p6_ay_q <= $signed({1'b0, p5_q.ke}) * p5_vny_q;
    p6_bx_q <= $signed({1'b0, p5_q.kf}) * p5_vtx_q;
    p6_by_q <= $signed({1'b0, p5_q.kf}) * p5_vty_q;
  end

  // ---------------------------------------------------------------------------
  // p7: new velocity, reflected normal plus damped tangent
  // ---------------------------------------------------------------------------
  logic               p7_vld_q;
  post_t              p7_q;
  logic signed [39:0] p7_wx_q;
  logic signed [39:0] p7_wy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p7_vld_q <= 1'b0;
    end else begin
      p7_vld_q <= p6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p7_q    <= p6_q;
    p7_wx_q <= 40'(rnd_shr(70'(p6_bx_q), 15)) - 40'(rnd_shr(70'(p6_ax_q), 15));
    p7_wy_q <= 40'(rnd_shr(70'(p6_by_q), 15)) - 40'(rnd_shr(70'(p6_ay_q), 15));
  end

  // ---------------------------------------------------------------------------
  // output register: previous position rebuilt, saturation, pass-through on miss
  // ---------------------------------------------------------------------------
  logic               out_vld_q;
  psc_pkg::out_t      out_q;
  psc_pkg::out_t      out_d;
  logic signed [40:0] bqx;
  logic signed [40:0] bqy;

  assign bqx = 41'(p7_q.npx) - 41'(p7_wx_q);
  assign bqy = 41'(p7_q.npy) - 41'(p7_wy_q);

  always_comb begin
    if (p7_q.hit) begin
      out_d.new_pos_x = sat32(41'(p7_q.npx));
      out_d.new_pos_y = sat32(41'(p7_q.npy));
      if (p7_q.bounce) begin
        out_d.new_prev_x = sat32(bqx);
        out_d.new_prev_y = sat32(bqy);
      end else begin
        out_d.new_prev_x = sat32(41'(p7_q.nqx));
        out_d.new_prev_y = sat32(41'(p7_q.nqy));
      end
      out_d.hit     = 1'b1;
      out_d.bounced = p7_q.bounce;
    end else begin
      out_d.new_pos_x  = p7_q.pos_x;
      out_d.new_pos_y  = p7_q.pos_y;
      out_d.new_prev_x = p7_q.prev_x;
      out_d.new_prev_y = p7_q.prev_y;
      out_d.hit        = 1'b0;
      out_d.bounced    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= p7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o   = out_vld_q;
  assign result_o = out_q;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the particle segment collision unit
module testbench;

  // wide signed arithmetic for the collision predictor, no overflow possible
  typedef logic signed [127:0] wide_t;

  localparam int Q1 = 65536;  // 1.0 in q16.16
  localparam int MaxI = 32'sh7fffffff;
  localparam int MinI = 32'sh80000000;
  localparam int ItemsPerPhase = 250;
  localparam int Latency = 111;

  // one row of the directed table: expectation typed in only where known by eye
  typedef struct {
    psc_pkg::in_t  item;
    bit            typed;
    psc_pkg::out_t want;
  } stim_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  psc_pkg::in_t  item_i = '0;
  logic          done_o;
  psc_pkg::out_t result_o;

  psc_pkg::out_t expected_q[$];  // predicted corrected particles, oldest first
  int            n_errors = 0;
  int            n_sent = 0;
  int            n_results = 0;
  int            n_hits = 0;
  int            n_bounces = 0;
  stim_row_t     rows[$];
  bit            row_typed = 1'b0;
  psc_pkg::out_t row_want;

  particle_segment_collision_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // hard stop in case the pipeline hangs or loses a strobe
  initial begin
    #4000000;
    $display("FAIL particle_segment_collision_unit");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
    n_errors++;
  endtask

  // round to nearest, halves away from zero, then drop s fraction bits
  function automatic wide_t round_drop(wide_t v, int s);
    wide_t m;
    m = (v < 0) ? -v : v;
    m = (m + (wide_t'(1) << (s - 1))) >> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic [31:0] clamp32(wide_t v);
    if (v > wide_t'(MaxI)) return MaxI;
    if (v < wide_t'(MinI)) return MinI;
    return v[31:0];
  endfunction

  // floor square root, bit by bit
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // normal component in q1.30, truncated toward zero
  function automatic wide_t normal_part(wide_t d, wide_t len);
    wide_t q;
    if (len == 0) return 0;
    q = (((d < 0) ? -d : d) << 30) / len;
    return (d < 0) ? -q : q;
  endfunction

  // full collision response of one pair
  function automatic psc_pkg::out_t predict_collision(psc_pkg::in_t it);
    wide_t px, py, qx, qy, e, kf, sxs, sys, tx, ty, dot, den, t;
    wide_t dx, dy, ax, ay, h, odd, lim, ds, dlen, ov, nx, ny, shx, shy;
    wide_t npx, npy, nqx, nqy, vx, vy, vraw, vn, vnx, vny, wx, wy;
    psc_pkg::out_t r;
    px = $signed(it.pos_x);
    py = $signed(it.pos_y);
    qx = $signed(it.prev_x);
    qy = $signed(it.prev_y);
    e = (it.bounce_coef > psc_pkg::CoefOne) ? psc_pkg::CoefOne : it.bounce_coef;
    kf = wide_t'(psc_pkg::CoefOne) - ((it.friction_coef > psc_pkg::CoefOne) ?
                                      psc_pkg::CoefOne : it.friction_coef);
    sxs = $signed(it.seg_start_x);
    sys = $signed(it.seg_start_y);
    tx = $signed(it.seg_end_x) - sxs;
    ty = $signed(it.seg_end_y) - sys;
    // projection parameter in q1.30, clamped to the segment
    dot = (px - sxs) * tx + (py - sys) * ty;
    den = tx * tx + ty * ty;
    if (dot <= 0) t = 0;
    else if (dot >= den) t = wide_t'(1) << 30;
    else t = (dot << 30) / den;
    dx = px - (sxs + round_drop(tx * t, 30));
    dy = py - (sys + round_drop(ty * t, 30));
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    h = wide_t'(it.particle_radius) + wide_t'(it.seg_thickness >> 1);
    odd = it.seg_thickness[0];
    lim = h * h + odd * h;
    r = '{clamp32(px), clamp32(py), clamp32(qx), clamp32(qy), 1'b0, 1'b0};
    ds = ax * ax + ay * ay;
    if (ax > h || ay > h || ds > lim) return r;
    dlen = floor_sqrt(ds[63:0]);
    ov = 2 * h + odd - 2 * dlen;
    nx = normal_part(dx, dlen);
    ny = normal_part(dy, dlen);
    // push-out moves position and previous position together
    shx = round_drop(ov * nx, 31);
    shy = round_drop(ov * ny, 31);
    npx = px + shx;
    npy = py + shy;
    nqx = qx + shx;
    nqy = qy + shy;
    vx = px - qx;
    vy = py - qy;
    vraw = vx * nx + vy * ny;
    r.hit = 1'b1;
    if (vraw < 0) begin
      // approaching: reflect the normal part, damp the tangential part
      vn = round_drop(vraw, 30);
      vnx = round_drop(vn * nx, 30);
      vny = round_drop(vn * ny, 30);
      wx = -round_drop(e * vnx, 15) + round_drop(kf * (vx - vnx), 15);
      wy = -round_drop(e * vny, 15) + round_drop(kf * (vy - vny), 15);
      nqx = npx - wx;
      nqy = npy - wy;
      r.bounced = 1'b1;
    end
    r.new_pos_x = clamp32(npx);
    r.new_pos_y = clamp32(npy);
    r.new_prev_x = clamp32(nqx);
    r.new_prev_y = clamp32(nqy);
    return r;
  endfunction

  function automatic psc_pkg::in_t make_pair(int px, int py, int qx, int qy,
                                             logic [30:0] rad, logic [15:0] e,
                                             logic [15:0] f, int sx, int sy,
                                             int ex, int ey, logic [30:0] thk);
    return '{px, py, qx, qy, rad, e, f, sx, sy, ex, ey, thk};
  endfunction

  // symmetric random offset of about 2^b
  function automatic int jitter(int b);
    return int'($urandom_range(0, 2 ** (b + 1))) - 2 ** b;
  endfunction

  // random pair: mostly a particle near a segment, some pure noise
  function automatic psc_pkg::in_t random_pair();
    psc_pkg::in_t it;
    logic [383:0] raw;
    int sc, rb, vb, sx, sy, ex, ey, px, py;
    sc = $urandom_range(6, 22);
    rb = $urandom_range(4, 20);
    vb = $urandom_range(2, 20);
    if ($urandom_range(0, 4) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(psc_pkg::in_t)-1:0];
      return it;
    end
    sx = int'($urandom) >>> $urandom_range(0, 12);
    sy = int'($urandom) >>> $urandom_range(0, 12);
    ex = ($urandom_range(0, 15) == 0) ? sx : sx + jitter(sc);
    ey = ($urandom_range(0, 15) == 0) ? sy : sy + jitter(sc);
    px = sx + ((ex - sx) >>> $urandom_range(0, 3)) + jitter(rb);
    py = sy + ((ey - sy) >>> $urandom_range(0, 3)) + jitter(rb);
    it = make_pair(px, py, px + jitter(vb), py + jitter(vb),
                   31'($urandom_range(0, 2 ** rb)),
                   16'(($urandom_range(0, 7) == 0) ? $urandom
                                                   : $urandom_range(0, psc_pkg::CoefOne)),
                   16'(($urandom_range(0, 7) == 0) ? $urandom
                                                   : $urandom_range(0, psc_pkg::CoefOne)),
                   sx, sy, ex, ey, 31'($urandom_range(0, 2 ** rb)));
    return it;
  endfunction

  // result checker and expectation store, both on the rising edge
  always @(posedge clk_i) begin
    psc_pkg::out_t want;
    if (done_o) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", result_o.new_pos_x, '0);
      end else begin
        want = expected_q.pop_front();
        if (result_o.new_pos_x !== want.new_pos_x)
          report_mismatch("new_pos_x", result_o.new_pos_x, want.new_pos_x);
        if (result_o.new_pos_y !== want.new_pos_y)
          report_mismatch("new_pos_y", result_o.new_pos_y, want.new_pos_y);
        if (result_o.new_prev_x !== want.new_prev_x)
          report_mismatch("new_prev_x", result_o.new_prev_x, want.new_prev_x);
        if (result_o.new_prev_y !== want.new_prev_y)
          report_mismatch("new_prev_y", result_o.new_prev_y, want.new_prev_y);
        if (result_o.hit !== want.hit)
          report_mismatch("hit", 32'(result_o.hit), 32'(want.hit));
        if (result_o.bounced !== want.bounced)
          report_mismatch("bounced", 32'(result_o.bounced), 32'(want.bounced));
        n_hits += want.hit;
        n_bounces += want.bounced;
      end
    end
    if (rst_ni && start && !busy) begin
      expected_q.push_back(row_typed ? row_want : predict_collision(item_i));
      n_sent++;
    end
  end

  // present one pair at the falling edge and hold it until the transfer
  task automatic send_pair(input psc_pkg::in_t it, input bit typed,
                           input psc_pkg::out_t want);
    start <= 1'b1;
    item_i <= it;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int idle_pct;
    // directed table: zero distance, pass-through at the extremes, corner
    // of the range, bounce, push-out only, clamped coefficients, full
    // friction, both ends of the segment, a point segment, odd thickness
    // and saturation both ways
    rows.push_back('{make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     '{0, 0, 0, 0, 1'b1, 1'b0}});
    rows.push_back('{make_pair(MaxI, MaxI, MinI, MinI, 0, 0, 0, MinI, MinI, MinI, MinI, 0),
                     1'b1, '{MaxI, MaxI, MinI, MinI, 1'b0, 1'b0}});
    rows.push_back('{make_pair(MaxI, MinI, MinI, MaxI, '1, '1, '1, MaxI, MinI, MaxI, MinI,
                     '1), 1'b1, '{MaxI, MinI, MinI, MaxI, 1'b1, 1'b0}});
    rows.push_back('{make_pair(0, Q1/2, 0, 3*Q1/2, Q1, psc_pkg::CoefOne/2, 0, -10*Q1, 0,
                     10*Q1, 0, 0), 1'b0, '0});
    rows.push_back('{make_pair(0, Q1/2, 0, -Q1/2, Q1, psc_pkg::CoefOne/2, 0, -10*Q1, 0,
                     10*Q1, 0, 0), 1'b0, '0});
    rows.push_back('{make_pair(Q1/4, Q1/2, 0, Q1, Q1, '1, '1, -10*Q1, 0, 10*Q1, 0, 0),
                     1'b0, '0});
    rows.push_back('{make_pair(Q1/4, Q1/2, Q1, Q1, Q1, 0, psc_pkg::CoefOne, -10*Q1, 0,
                     10*Q1, 0, Q1), 1'b0, '0});
    rows.push_back('{make_pair(11*Q1, Q1/2, 11*Q1, Q1, Q1, psc_pkg::CoefOne, 0, -10*Q1, 0,
                     10*Q1, 0, 0), 1'b0, '0});
    rows.push_back('{make_pair(-11*Q1, -Q1/2, -10*Q1, -Q1, Q1, psc_pkg::CoefOne, 0, -10*Q1,
                     0, 10*Q1, 0, 0), 1'b0, '0});
    rows.push_back('{make_pair(Q1/2, Q1/4, Q1, Q1, Q1, psc_pkg::CoefOne,
                     psc_pkg::CoefOne/4, 0, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{make_pair(0, 1, 0, 2, 0, psc_pkg::CoefOne, 0, -5, 0, 5, 0, 3), 1'b0,
                     '0});
    rows.push_back('{make_pair(0, MaxI, 0, MinI, 4*Q1, psc_pkg::CoefOne, 0, -Q1, MaxI - Q1,
                     Q1, MaxI - Q1, 0), 1'b0, '0});
    rows.push_back('{make_pair(0, MaxI - Q1/2, 0, MaxI, 4*Q1, psc_pkg::CoefOne, 0, -Q1,
                     MaxI - Q1, Q1, MaxI - Q1, 0), 1'b0, '0});
    rows.push_back('{make_pair(MinI + Q1/2, 0, MaxI, 0, 4*Q1, psc_pkg::CoefOne, 0,
                     MinI + Q1, -Q1, MinI + Q1, Q1, '1), 1'b0, '0});
    rows.push_back('{make_pair(Q1/2 + Q1/8, Q1/2 - Q1/8, Q1, 0, Q1/4, psc_pkg::CoefOne,
                     psc_pkg::CoefOne/2, 0, 0, Q1, Q1, Q1/8), 1'b0, '0});
    rows.push_back('{make_pair(MinI, MaxI, MaxI, MinI, '1, 0, '1, MaxI, MinI, MinI, MaxI, '1),
                     1'b0, '0});

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_pair(rows[i].item, rows[i].typed, rows[i].want);

    // random phases: back to back, mostly idle, lightly idle
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 68 : (phase == 3) ? 28 : 0;
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (idle_pct != 0) begin
          while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk_i);
          end
        end
        send_pair(random_pair(), 1'b0, '0);
      end
      if (phase == 2) begin
        // hold off until the pipe has fully drained, then restart
        start <= 1'b0;
        @(negedge clk_i);
        wait (expected_q.size() == 0);
        @(negedge clk_i);
      end
    end
    start <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (Latency + 20) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0d results never arrived", expected_q.size());
      n_errors++;
    end

    $display("sent %0d pairs, checked %0d results: %0d overlaps, %0d reflections",
             n_sent, n_results, n_hits, n_bounces);
    $display("directed corner rows plus random near-wall and noise pairs under idle mixes");
    if (n_errors == 0) begin
      $display("PASS particle_segment_collision_unit");
    end else begin
      $display("FAIL particle_segment_collision_unit");
    end
    $finish;
  end

endmodule
